@@ design/sra_pkg.sv @@
// Shared types and constants for the staging ring allocator.
`timescale 1ns / 1ps

package sra_pkg;

    // Field widths fixed by the interface
    localparam int SIZE_W   = 27;
    localparam int FENCE_W  = 48;
    localparam int OFFSET_W = 26;
    localparam int STATUS_W = 2;

    // Head alignment in bytes
    localparam int ALIGN_BYTES = 4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_GRANT    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_WAIT     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERSIZE = 2'd2;

    // Controller states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ALIGN  = 5'b00010,
        ST_FETCH  = 5'b00100,
        ST_CHECK  = 5'b01000,
        ST_DECIDE = 5'b10000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch;     // capture the request word
        logic align;     // align / wrap the head
        logic fetch;     // read the oldest live entry
        logic pop;       // retire the oldest live entry
        logic set_tail;  // tail follows the oldest live entry
        logic decide;    // produce the result word
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic oversize;
        logic live_empty;
        logic fence_done;
        logic out_busy;
    } stat_t;

endpackage

@@ design/sra_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/sra_ctrl.sv @@
// Controller state machine of the staging ring allocator.
`timescale 1ns / 1ps

module sra_ctrl import sra_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN:
            begin
                // oversized words leave all state untouched
                if (stat.oversize)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cmd.align  = 1'b1;
                    cmd.fetch  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!stat.live_empty && stat.fence_done)
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_FETCH;
                end
                else
                begin
                    cmd.set_tail = 1'b1;
                    state_next   = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.decide = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/sra_datapath.sv @@
// Datapath: head, tail, fence, live-block queue and result register.
`timescale 1ns / 1ps

module sra_datapath import sra_pkg::*; #(
    parameter int RING_BYTES      = 67108864,
    parameter int MAX_LIVE_BLOCKS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic [SIZE_W-1:0]   req_size,
    input  logic [FENCE_W-1:0]  completed_fence,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [OFFSET_W-1:0] grant_offset,
    output logic [FENCE_W-1:0]  grant_fence,
    output logic [FENCE_W-1:0]  wait_fence
);

    // Head offset width (head may equal the ring size)
    localparam int HW    = $clog2(RING_BYTES + 1);
    // Sum width for aligned head plus size
    localparam int SW    = ((HW > SIZE_W) ? HW : SIZE_W) + 1;
    localparam int PW    = $clog2(MAX_LIVE_BLOCKS);
    localparam int CNT_W = $clog2(MAX_LIVE_BLOCKS + 1);
    localparam int ENT_W = FENCE_W + HW;
    localparam logic [SW-1:0]    RING_W   = SW'(RING_BYTES);
    localparam logic [SW-1:0]    ALIGN_M  = SW'(ALIGN_BYTES - 1);
    localparam logic [PW-1:0]    LAST_PTR = PW'(MAX_LIVE_BLOCKS - 1);
    localparam logic [CNT_W:0]   MAX_SUM  = (CNT_W + 1)'(MAX_LIVE_BLOCKS);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_LIVE_BLOCKS);

    logic [HW-1:0]      head_reg, tail_reg;
    logic [FENCE_W-1:0] last_fence_reg;
    logic [PW-1:0]      rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               out_valid_reg;

    logic [SIZE_W-1:0]  size_reg;
    logic [FENCE_W-1:0] done_reg;
    logic [HW-1:0]      aligned_reg;
    logic               wrapped_reg;

    logic [STATUS_W-1:0] status_reg;
    logic [OFFSET_W-1:0] goffs_reg;
    logic [FENCE_W-1:0]  gfence_reg, wfence_reg;

    logic [ENT_W-1:0]   rd_data;
    logic [FENCE_W-1:0] ent_fence;
    logic [HW-1:0]      ent_offset;

    assign ent_fence  = rd_data[ENT_W-1:HW];
    assign ent_offset = rd_data[HW-1:0];

    // Request size, head rounding and wrap test
    logic [SW-1:0] size_ext, head_ext, rnd_ext, fit_sum;
    logic          wrap;

    assign size_ext = SW'(size_reg);
    assign head_ext = SW'(head_reg);
    assign rnd_ext  = (head_ext + ALIGN_M) & ~ALIGN_M;
    assign fit_sum  = rnd_ext + size_ext;
    assign wrap     = (rnd_ext >= RING_W) || (fit_sum > RING_W);

    // Space test on the latched aligned head
    logic [SW-1:0] al_ext, tail_ext, end_ext;
    logic          live_empty, space;

    assign al_ext     = SW'(aligned_reg);
    assign tail_ext   = SW'(tail_reg);
    assign end_ext    = al_ext + size_ext;
    assign live_empty = (count_reg == '0);

    always_comb
    begin
        if (live_empty)
        begin
            space = 1'b1;
        end
        else if (aligned_reg == tail_reg)
        begin
            space = 1'b0;
        end
        else if (wrapped_reg || (aligned_reg < tail_reg))
        begin
            space = (end_ext <= tail_ext);
        end
        else
        begin
            space = 1'b1;
        end
        if (count_reg >= MAX_CNT)
        begin
            space = 1'b0;
        end
    end

    // Slot for a new entry: read pointer plus count, modulo depth
    logic [CNT_W:0] wr_sum, wr_mod;
    logic [PW-1:0]  wr_addr;
    logic           grant;

    assign wr_sum  = (CNT_W + 1)'(rd_ptr_reg) + (CNT_W + 1)'(count_reg);
    assign wr_mod  = (wr_sum >= MAX_SUM) ? (wr_sum - MAX_SUM) : wr_sum;
    assign wr_addr = wr_mod[PW-1:0];
    assign grant   = cmd.decide && !stat.oversize && space;

    logic [FENCE_W-1:0] fence_inc;
    assign fence_inc = last_fence_reg + FENCE_W'(1);

    sra_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_LIVE_BLOCKS)
    ) u_live (
        .clk     (clk),
        .wr_en   (grant),
        .wr_addr (wr_addr),
        .wr_data ({fence_inc, aligned_reg}),
        .rd_en   (cmd.fetch),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    // Status to controller
    assign stat.oversize   = (size_ext > RING_W);
    assign stat.live_empty = live_empty;
    assign stat.fence_done = (ent_fence <= done_reg);
    assign stat.out_busy   = out_valid_reg && !out_ready;

    // Request word and alignment result
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            size_reg <= req_size;
            done_reg <= completed_fence;
        end
        if (cmd.align)
        begin
            aligned_reg <= wrap ? '0 : rnd_ext[HW-1:0];
            wrapped_reg <= wrap;
        end
    end

    // Allocator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            last_fence_reg <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            // a wrap resets the head even if the answer is wait
            if (cmd.align && wrap)
            begin
                head_reg <= '0;
            end
            if (cmd.pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
                count_reg  <= count_reg - CNT_W'(1);
            end
            if (cmd.set_tail && !live_empty)
            begin
                tail_reg <= ent_offset;
            end
            if (grant)
            begin
                count_reg      <= count_reg + CNT_W'(1);
                last_fence_reg <= fence_inc;
                head_reg       <= end_ext[HW-1:0];
            end
        end
    end

    // Result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.decide)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            goffs_reg  <= '0;
            gfence_reg <= '0;
            wfence_reg <= '0;
            if (stat.oversize)
            begin
                status_reg <= STATUS_OVERSIZE;
            end
            else if (space)
            begin
                status_reg <= STATUS_GRANT;
                goffs_reg  <= al_ext[OFFSET_W-1:0];
                gfence_reg <= fence_inc;
            end
            else
            begin
                status_reg <= STATUS_WAIT;
                wfence_reg <= ent_fence;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign grant_offset = goffs_reg;
    assign grant_fence  = gfence_reg;
    assign wait_fence   = wfence_reg;

endmodule

@@ design/staging_ring_allocator.sv @@
// Top level of the staging ring allocator: controller plus datapath.
// Each accepted word goes through align, then fetch and check of the oldest live
// block until one is not retired, then decide; an oversized request goes from align
// straight to decide. Each retirement is one read of the live-block RAM (registered
// read) and one fence compare. A new word is accepted only in idle; a waiting result
// does not block acceptance of the next word, only its final decision step.
// Reset (rst_n, async, active low) empties the queue and clears head, tail and
// fence; the live-block RAM is not cleared.
`timescale 1ns / 1ps

module staging_ring_allocator import sra_pkg::*; #(
    parameter int RING_BYTES      = 67108864,
    parameter int MAX_LIVE_BLOCKS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SIZE_W-1:0]   req_size,
    input  logic [FENCE_W-1:0]  completed_fence,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [OFFSET_W-1:0] grant_offset,
    output logic [FENCE_W-1:0]  grant_fence,
    output logic [FENCE_W-1:0]  wait_fence
);

    cmd_t  cmd;
    stat_t stat;

    sra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sra_datapath #(
        .RING_BYTES      (RING_BYTES),
        .MAX_LIVE_BLOCKS (MAX_LIVE_BLOCKS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_size        (req_size),
        .completed_fence (completed_fence),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .grant_offset    (grant_offset),
        .grant_fence     (grant_fence),
        .wait_fence      (wait_fence)
    );

endmodule

@@ dv/staging_ring_allocator_tb.sv @@
// Testbench for the staging ring allocator: directed and random request traffic, predictor, in-order checks.
`timescale 1ns / 1ps

module staging_ring_allocator_tb;
    import sra_pkg::*;

    localparam int RING        = 67108864;
    localparam int LIVE_MAX    = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 200;
    localparam int RANDOM_REQS = 1700;

    typedef enum int {PH_SLOW_SINK, PH_SLOW_SOURCE, PH_FULL_RATE} traffic_t;

    // Pending request: fence_arg is a lag behind the last granted fence when relative is set
    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic               relative;
        logic [FENCE_W-1:0] fence_arg;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFFSET_W-1:0] offset;
        logic [FENCE_W-1:0]  gfence;
        logic [FENCE_W-1:0]  wfence;
    } answer_t;

    logic                clk             = 1'b0;
    logic                rst_n           = 1'b0;
    logic                in_valid        = 1'b0;
    logic                in_ready;
    logic [SIZE_W-1:0]   req_size        = '0;
    logic [FENCE_W-1:0]  completed_fence = '0;
    logic                out_valid;
    logic                out_ready       = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] grant_offset;
    logic [FENCE_W-1:0]  grant_fence;
    logic [FENCE_W-1:0]  wait_fence;

    // Allocator state as predicted
    logic [27:0]         ring_head  = '0;
    logic [OFFSET_W-1:0] ring_tail  = '0;
    logic [FENCE_W-1:0]  fence_last = '0;
    logic [OFFSET_W-1:0] blk_off   [LIVE_MAX];
    logic [FENCE_W-1:0]  blk_fence [LIVE_MAX];
    int                  blk_rd     = 0;
    int                  blk_cnt    = 0;

    request_t request_q[$];
    answer_t  pending_answers[$];
    request_t next_req;
    answer_t  got_ans;
    int       n_total   = 0;
    int       n_issued  = 0;
    int       n_errors  = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    int       src_idle[3]  = '{33, 80, 0};
    int       sink_idle[3] = '{80, 33, 0};

    staging_ring_allocator #(
        .RING_BYTES      (RING),
        .MAX_LIVE_BLOCKS (LIVE_MAX)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_size        (req_size),
        .completed_fence (completed_fence),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .grant_offset    (grant_offset),
        .grant_fence     (grant_fence),
        .wait_fence      (wait_fence)
    );

    always #5 clk = ~clk;

    function automatic traffic_t traffic_phase();
        if (n_issued * 3 < n_total)
            return PH_SLOW_SINK;
        if (n_issued * 3 < n_total * 2)
            return PH_SLOW_SOURCE;
        return PH_FULL_RATE;
    endfunction

    // Retire, wrap and place one request; queues the answer it must produce
    function automatic void decide_request(input logic [SIZE_W-1:0] size,
                                           input logic [FENCE_W-1:0] done);
        logic [27:0] aligned;
        bit          wrapped;
        bit          room;
        int          wr;
        answer_t     ans;
        ans = '0;
        ans.status = STATUS_GRANT;
        if (size > RING)
        begin
            ans.status = STATUS_OVERSIZE;
        end
        else
        begin
            aligned = ring_head + 28'(ALIGN_BYTES - 1);
            aligned = aligned & ~28'(ALIGN_BYTES - 1);
            wrapped = 1'b0;
            if (aligned >= RING || aligned + size > RING)
            begin
                aligned   = '0;
                ring_head = '0;
                wrapped   = 1'b1;
            end
            // retire completed blocks, oldest first
            while (blk_cnt > 0 && blk_fence[blk_rd] <= done)
            begin
                blk_rd  = (blk_rd + 1) % LIVE_MAX;
                blk_cnt = blk_cnt - 1;
            end
            if (blk_cnt > 0)
                ring_tail = blk_off[blk_rd];
            if (blk_cnt == 0)
                room = 1'b1;
            else if (aligned == ring_tail)
                room = 1'b0;
            else if (wrapped || aligned < ring_tail)
                room = (aligned + size <= ring_tail);
            else
                room = 1'b1;
            if (blk_cnt >= LIVE_MAX)
                room = 1'b0;
            if (!room)
            begin
                ans.status = STATUS_WAIT;
                ans.wfence = blk_fence[blk_rd];
            end
            else
            begin
                fence_last     = fence_last + 1'b1;
                wr             = (blk_rd + blk_cnt) % LIVE_MAX;
                blk_off[wr]    = aligned[OFFSET_W-1:0];
                blk_fence[wr]  = fence_last;
                blk_cnt        = blk_cnt + 1;
                ring_head      = aligned + size;
                ans.offset     = aligned[OFFSET_W-1:0];
                ans.gfence     = fence_last;
            end
        end
        pending_answers.insert(pending_answers.size(), ans);
    endfunction

    function automatic void check_field(input string field, input logic [FENCE_W-1:0] want,
                                        input logic [FENCE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            n_errors++;
        end
    endfunction

    task automatic add_req(input logic [SIZE_W-1:0] size, input logic relative,
                           input logic [FENCE_W-1:0] arg);
        request_t r;
        r.size      = size;
        r.relative  = relative;
        r.fence_arg = arg;
        request_q.insert(request_q.size(), r);
    endtask

    // Request driver: predicts at acceptance, resolves relative fences at load
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                decide_request(req_size, completed_fence);
                n_issued <= n_issued + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (request_q.size() != 0 &&
                    $urandom_range(99) >= src_idle[traffic_phase()])
                begin
                    next_req = request_q.pop_front();
                    in_valid <= 1'b1;
                    req_size <= next_req.size;
                    if (!next_req.relative)
                        completed_fence <= next_req.fence_arg;
                    else if (fence_last >= next_req.fence_arg)
                        completed_fence <= fence_last - next_req.fence_arg;
                    else
                        completed_fence <= '0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result sink: random stalls, plus one long hold-off when full rate starts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && traffic_phase() == PH_FULL_RATE)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= sink_idle[traffic_phase()]);
        end
    end

    // Result monitor: compare each accepted word against the oldest answer due
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result word, status %0d", status);
                n_errors++;
            end
            else
            begin
                got_ans = pending_answers.pop_front();
                check_field("status", FENCE_W'(got_ans.status), FENCE_W'(status));
                check_field("grant_offset", FENCE_W'(got_ans.offset),
                            FENCE_W'(grant_offset));
                check_field("grant_fence", got_ans.gfence, grant_fence);
                check_field("wait_fence", got_ans.wfence, wait_fence);
            end
        end
    end

    initial
    begin
        int n_rand;
        int len;
        int kind;
        logic [SIZE_W-1:0] sz;

        // Directed: oversize, alignment, wrap on wait, ring full, store empty, zero size, ring size less one at end
        add_req(27'h7FF_FFFF, 1'b0, 48'd0);
        add_req(SIZE_W'(RING + 1), 1'b0, 48'd0);
        add_req(27'd0, 1'b0, 48'd0);
        add_req(27'd5, 1'b0, 48'd1);
        add_req(27'd3, 1'b0, 48'd1);
        add_req(SIZE_W'(RING), 1'b0, 48'd1);
        add_req(27'd4, 1'b0, 48'd2);
        add_req(27'd8, 1'b0, 48'd2);
        add_req(27'd4, 1'b0, 48'd2);
        add_req(27'd1, 1'b0, 48'd2);
        add_req(SIZE_W'(RING), 1'b0, 48'hFFFF_FFFF_FFFF);
        add_req(27'd0, 1'b0, 48'd5);
        add_req(27'd0, 1'b0, 48'd6);
        repeat (4) add_req(SIZE_W'(RING / 4), 1'b0, 48'd7);
        add_req(27'd16, 1'b0, 48'd7);
        add_req(27'd16, 1'b0, 48'd8);
        add_req(SIZE_W'(RING - 1), 1'b0, 48'd0);

        // Random: mostly coherent traffic with relative fences, some noise
        n_rand = 0;
        while (n_rand < RANDOM_REQS)
        begin
            kind = $urandom_range(99);
            if (kind < 35)
            begin
                // steady upload stream, consumer a few fences behind
                len = $urandom_range(8, 40);
                repeat (len)
                begin
                    sz = ($urandom_range(9) == 0) ? SIZE_W'($urandom_range(1 << 20))
                                                  : SIZE_W'($urandom_range(4096));
                    add_req(sz, 1'b1, FENCE_W'($urandom_range(6)));
                end
            end
            else if (kind < 55)
            begin
                // consumer stalled: fills the in-flight store
                len = $urandom_range(60, 80);
                repeat (len)
                    add_req(SIZE_W'($urandom_range(64)), 1'b1,
                            FENCE_W'($urandom_range(70, 200)));
            end
            else if (kind < 75)
            begin
                // large blocks: wraps and a full ring
                len = $urandom_range(6, 20);
                repeat (len)
                begin
                    sz = ($urandom_range(1) == 0) ? SIZE_W'(RING >> $urandom_range(4))
                                                  : SIZE_W'($urandom_range(RING / 8, RING));
                    add_req(sz, 1'b1, FENCE_W'($urandom_range(3)));
                end
            end
            else if (kind < 85)
            begin
                // completed fence going back
                len = $urandom_range(4, 10);
                repeat (len)
                    add_req(SIZE_W'($urandom_range(256)), 1'b0,
                            FENCE_W'($urandom_range(50)));
            end
            else
            begin
                // noise over the whole field ranges
                len = $urandom_range(3, 10);
                repeat (len)
                    add_req(SIZE_W'($urandom()), 1'b0, FENCE_W'({$urandom(), $urandom()}));
            end
            n_rand += len;
        end
        n_total = request_q.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (n_errors == 0 && pending_answers.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
